### src/plt_pkg.sv
// ----------------------------------------------------------------------------
// plt_pkg: shared types for the positional list table
// Holds the request kinds, the cell command and the result word layout.
// ----------------------------------------------------------------------------
package plt_pkg;

   // Request kinds as carried on the req_type port.
   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_MODIFY = 2'd2,
      REQ_SEARCH = 2'd3
   } req_kind_type;

   // What every cell does in a cycle.
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_WRITE
   } cell_op_type;

   // Command broadcast along the row of cells. The index is 0-based and
   // never exceeds what a 7-bit position can name.
   typedef struct packed {
      cell_op_type        op;
      logic [6:0]         index;
      logic signed [31:0] value;
   } cell_cmd_type;

   // One result word.
   typedef struct packed {
      logic       success;
      logic [6:0] found_position;
      logic [6:0] list_length;
   } rsp_word_type;

endpackage

### src/plt_cell.sv
// ----------------------------------------------------------------------------
// plt_cell: one entry of the positional list
// Holds one word, takes it from a neighbor on a shift, and flags a match.
// ----------------------------------------------------------------------------
module plt_cell #(
   parameter int IDX = 0,
   parameter int CW  = 7
) (
   input  logic                 clock,
   input  plt_pkg::cell_cmd_type cmd,
   input  logic [CW-1:0]        count,
   input  logic signed [31:0]   left_word,
   input  logic signed [31:0]   right_word,
   output logic signed [31:0]   word,
   output logic                 hit
);
   import plt_pkg::*;

   localparam logic [31:0] IdxW = 32'(IDX);

   logic signed [31:0] word_ff;
   logic signed [31:0] word_in;
   logic [31:0]        target;
   logic               live;

   assign target = 32'(cmd.index);
   assign live   = IdxW < 32'(count);

   always_comb begin
      word_in = word_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (IdxW > target) begin
               word_in = left_word;
            end else if (IdxW == target) begin
               word_in = cmd.value;
            end
         end
         CELL_REMOVE: begin
            if (IdxW >= target) begin
               word_in = right_word;
            end
         end
         CELL_WRITE: begin
            if (IdxW == target) begin
               word_in = cmd.value;
            end
         end
         default: word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;
   assign hit  = live && (word_ff == cmd.value);

endmodule

### src/positional_list_table_top.sv
// ----------------------------------------------------------------------------
// positional_list_table_top: ordered list with insert, remove, modify, search
// A row of cells holds the list; a group scanner finds the first match.
// ----------------------------------------------------------------------------
// Insert, remove and modify: the result word is registered at acceptance,
// into the output slot, or into the spare slot when the output slot is full
// and stalled; a new request can follow every cycle while req_stall is low.
// Search: the match flags of all cells are captured at acceptance, then a
// scanner reads eight flags per cycle until a group holds a match or the last
// group is read; requests stall meanwhile. Reset empties the list; entry contents need no clearing.
// ----------------------------------------------------------------------------
module positional_list_table_top #(
   parameter int CAPACITY = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic [6:0]         req_position,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_success,
   output logic [6:0]         rsp_found_position,
   output logic [6:0]         rsp_list_length
);
   import plt_pkg::*;

   // Count width holds CAPACITY itself; EW is wide enough for count + 1
   // and for any 7-bit position.
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = ((CW > 7) ? CW : 7) + 1;
   // The scanner walks the match flags in groups of eight.
   localparam int NG = (CAPACITY + 7) / 8;
   localparam int GW = (NG > 1) ? $clog2(NG) : 1;
   localparam logic [GW-1:0] LastGroup = GW'(NG - 1);
   localparam logic [EW-1:0] CapE = EW'(CAPACITY);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type          state_ff;
   logic [CW-1:0]      cnt_ff;
   logic [NG*8-1:0]    hits_ff;
   logic [GW-1:0]      group_ff;
   logic               rsp_valid_ff;
   rsp_word_type       rsp_word_ff;
   logic               hold_valid_ff;
   rsp_word_type       hold_word_ff;

   logic               req_accept;
   logic               rsp_fire;
   logic [EW-1:0]      pos_e;
   logic [EW-1:0]      cnt_e;
   logic               ins_ok;
   logic               upd_ok;
   logic               op_ok;
   logic [CW-1:0]      cnt_next;
   cell_cmd_type       cmd;
   logic [NG*8-1:0]    hit_vec;
   logic signed [31:0] words [CAPACITY];
   logic [7:0]         group_bits;
   logic               group_any;
   logic [2:0]         group_first;
   logic [GW+3:0]      scan_pos;
   logic               done_now;
   rsp_word_type       done_word;

   // A word is accepted only when no search is running and the spare
   // result slot is free, so a finished word may still wait at the output.
   assign req_stall  = (state_ff == ST_SCAN) || hold_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_fire   = rsp_valid_ff && !rsp_stall;

   // Position checks, done in a width that holds count + 1.
   assign pos_e  = EW'(req_position);
   assign cnt_e  = EW'(cnt_ff);
   assign ins_ok = (pos_e != '0) && (pos_e <= cnt_e + EW'(1)) && (cnt_e < CapE);
   assign upd_ok = (pos_e != '0) && (pos_e <= cnt_e);

   always_comb begin
      op_ok    = 1'b0;
      cnt_next = cnt_ff;
      cmd.op    = CELL_HOLD;
      cmd.index = req_position - 7'd1;
      cmd.value = req_value;
      if (req_accept) begin
         case (req_type)
            REQ_INSERT: begin
               if (ins_ok) begin
                  op_ok    = 1'b1;
                  cnt_next = cnt_ff + CW'(1);
                  cmd.op   = CELL_INSERT;
               end
            end
            REQ_REMOVE: begin
               if (upd_ok) begin
                  op_ok    = 1'b1;
                  cnt_next = cnt_ff - CW'(1);
                  cmd.op   = CELL_REMOVE;
               end
            end
            REQ_MODIFY: begin
               if (upd_ok) begin
                  op_ok  = 1'b1;
                  cmd.op = CELL_WRITE;
               end
            end
            default: op_ok = 1'b0;
         endcase
      end
   end

   // The row of cells. Cells above an insert point take their left neighbor,
   // cells from a removed one up their right one; the ends see harmless stand-ins.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [31:0] left_w;
      logic signed [31:0] right_w;
      if (i == 0) begin : g_first
         assign left_w = req_value;
      end else begin : g_mid_l
         assign left_w = words[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_w = words[i];
      end else begin : g_mid_r
         assign right_w = words[i+1];
      end
      plt_cell #(
         .IDX(i),
         .CW (CW)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .count     (cnt_ff),
         .left_word (left_w),
         .right_word(right_w),
         .word      (words[i]),
         .hit       (hit_vec[i])
      );
   end

   if (NG * 8 > CAPACITY) begin : g_pad
      assign hit_vec[NG*8-1:CAPACITY] = '0;
   end

   // First set flag within the current group of eight.
   assign group_bits = hits_ff[group_ff*8 +: 8];
   assign group_any  = |group_bits;

   always_comb begin
      group_first = 3'd0;
      for (int j = 7; j >= 0; j--) begin
         if (group_bits[j]) begin
            group_first = 3'(j);
         end
      end
   end

   assign scan_pos = {1'b0, group_ff, group_first} + (GW+4)'(1);

   // A result word is finished either right at acceptance of a non-search
   // request or at the end of a scan.
   always_comb begin
      done_now  = 1'b0;
      done_word = '0;
      if (req_accept && (req_type != REQ_SEARCH)) begin
         done_now                 = 1'b1;
         done_word.success        = op_ok;
         done_word.found_position = 7'd0;
         done_word.list_length    = 7'(cnt_next);
      end else if ((state_ff == ST_SCAN) && (group_any || (group_ff == LastGroup))) begin
         done_now                 = 1'b1;
         done_word.success        = group_any;
         done_word.found_position = group_any ? 7'(scan_pos) : 7'd0;
         done_word.list_length    = 7'(cnt_ff);
      end
   end

   // Control state, list length and the two result slots.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_next;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept && (req_type == REQ_SEARCH)) begin
                  state_ff <= ST_SCAN;
                  hits_ff  <= hit_vec;
                  group_ff <= '0;
               end
            end
            ST_SCAN: begin
               if (group_any || (group_ff == LastGroup)) begin
                  state_ff <= ST_IDLE;
               end else begin
                  group_ff <= group_ff + GW'(1);
               end
            end
            default: state_ff <= ST_IDLE;
         endcase

         if (done_now) begin
            if (!rsp_valid_ff || rsp_fire) begin
               rsp_valid_ff <= 1'b1;
               rsp_word_ff  <= done_word;
            end else begin
               hold_valid_ff <= 1'b1;
               hold_word_ff  <= done_word;
            end
         end else if (rsp_fire) begin
            if (hold_valid_ff) begin
               rsp_word_ff   <= hold_word_ff;
               hold_valid_ff <= 1'b0;
            end else begin
               rsp_valid_ff <= 1'b0;
            end
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_success        = rsp_word_ff.success;
   assign rsp_found_position = rsp_word_ff.found_position;
   assign rsp_list_length    = rsp_word_ff.list_length;

   // The list never grows past its capacity.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      EW'(cnt_ff) <= CapE)
      else $error("list length exceeds capacity");

   // The spare slot is only filled behind an occupied output slot.
   a_hold_behind: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> rsp_valid_ff)
      else $error("spare result slot filled while output slot empty");

   // A non-search request leaves the output slot valid on the next cycle.
   a_quick_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_type != REQ_SEARCH)) |=> rsp_valid_ff)
      else $error("result word missing after non-search request");

   // A reported position always comes with success.
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_word_ff.found_position != 7'd0)) |-> rsp_word_ff.success)
      else $error("found position without success");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for positional_list_table_top
// A queue of requests feeds a clocked driver that sends them in bursts. A
// clocked monitor predicts each accepted request against a private copy of
// the list and checks every result word, field by field, in order.
// ----------------------------------------------------------------------------
module testbench;

   import plt_pkg::*;

   localparam int CAPACITY       = 64;
   localparam int ITEM_TOTAL     = 900;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 400;
   localparam int HOLD_AFTER     = 300;
   localparam int SETTLE_CYCLES  = 20;

   // Shapes of a random segment of requests.
   localparam int SEG_GROW   = 0;
   localparam int SEG_SHRINK = 1;
   localparam int SEG_MIXED  = 2;
   localparam int SEG_BROKEN = 3;

   // Patterns the receiver switches between outside its one long hold-off.
   localparam int STALL_NONE     = 0;
   localparam int STALL_COIN     = 1;
   localparam int STALL_HEAVY    = 2;
   localparam int STALL_PERIODIC = 3;

   // One request word waiting in the driver's queue. When drain_first is set,
   // the driver holds it back until every earlier result word has come in.
   typedef struct packed {
      logic               drain_first;
      req_kind_type       kind;
      logic [6:0]         position;
      logic signed [31:0] value;
   } list_request_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_type = REQ_SEARCH;
   logic [6:0]         req_position = '0;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_success;
   logic [6:0]         rsp_found_position;
   logic [6:0]         rsp_list_length;

   positional_list_table_top #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_success        (rsp_success),
      .rsp_found_position (rsp_found_position),
      .rsp_list_length    (rsp_list_length)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Shared bookkeeping. The monitor writes these at the rising edge; the
   // driver, the receiver and the end-of-run process read them at the
   // falling edge, so no read races a write.
   // ------------------------------------------------------------------------
   list_request_type   pending_requests[$];
   rsp_word_type       expected_rsps[$];
   rsp_word_type       expected_word;
   list_request_type   next_request;
   int                 planned_items = 0;
   int                 accepted_reqs = 0;
   int                 checked_rsps = 0;
   int                 mismatch_count = 0;
   int                 idle_cycles = 0;
   logic               req_taken = 1'b0;

   // Private copy of the list that the predictor keeps in step with the block.
   logic signed [31:0] list_words [CAPACITY];
   int                 list_count = 0;

   // Coverage tallies for the closing summary.
   int                 search_hits = 0;
   int                 search_misses = 0;
   int                 full_rejects = 0;
   int                 position_rejects = 0;
   int                 peak_length = 0;

   // Stimulus planning: a running length estimate, so that generated
   // positions can be aimed at the valid range or just outside it.
   int                 plan_length = 0;
   logic signed [31:0] word_pool [16];

   // ------------------------------------------------------------------------
   // Predictor: applies one request to the private list and returns the
   // result word that the block must produce for it.
   // ------------------------------------------------------------------------
   function automatic rsp_word_type apply_request(req_kind_type kind, logic [6:0] pos,
                                                  logic signed [31:0] word);
      rsp_word_type outcome;
      int           p;
      int           i;
      outcome = '0;
      p = int'(pos);
      case (kind)
         REQ_INSERT: begin
            if (p >= 1 && p <= list_count + 1 && list_count < CAPACITY) begin
               for (i = list_count; i >= p; i--)
                  list_words[i] = list_words[i - 1];
               list_words[p - 1] = word;
               list_count++;
               outcome.success = 1'b1;
            end else if (list_count == CAPACITY) begin
               full_rejects++;
            end else begin
               position_rejects++;
            end
         end
         REQ_REMOVE: begin
            if (p >= 1 && p <= list_count) begin
               for (i = p; i < list_count; i++)
                  list_words[i - 1] = list_words[i];
               list_count--;
               outcome.success = 1'b1;
            end else begin
               position_rejects++;
            end
         end
         REQ_MODIFY: begin
            if (p >= 1 && p <= list_count) begin
               list_words[p - 1] = word;
               outcome.success = 1'b1;
            end else begin
               position_rejects++;
            end
         end
         default: begin
            // The lowest matching position wins; later duplicates are ignored.
            for (i = 0; i < list_count; i++) begin
               if (list_words[i] == word) begin
                  outcome.found_position = 7'(i + 1);
                  outcome.success = 1'b1;
                  break;
               end
            end
            if (outcome.success)
               search_hits++;
            else
               search_misses++;
         end
      endcase
      if (list_count > peak_length)
         peak_length = list_count;
      outcome.list_length = 7'(list_count);
      return outcome;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------------
   task automatic queue_request(input req_kind_type kind, input int pos,
                                input logic signed [31:0] word, input bit drain_first);
      list_request_type item;
      item.drain_first = drain_first;
      item.kind = kind;
      item.position = 7'(pos);
      item.value = word;
      pending_requests.push_back(item);
      if (kind == REQ_INSERT && pos >= 1 && pos <= plan_length + 1 && plan_length < CAPACITY)
         plan_length++;
      else if (kind == REQ_REMOVE && pos >= 1 && pos <= plan_length)
         plan_length--;
   endtask

   // Draws from a small pool with a chance of pool_percent so that searches find
   // matches and duplicates build up; otherwise any 32-bit word.
   function automatic logic signed [31:0] pick_word(int pool_percent);
      if ($urandom_range(0, 99) < pool_percent)
         return word_pool[$urandom_range(0, 15)];
      return $urandom;
   endfunction

   // A position from 1 to top, leaning on both ends of the list.
   function automatic int pick_valid_position(int top);
      if (top < 1)
         top = 1;
      case ($urandom_range(0, 3))
         0: return 1;
         1: return top;
         default: return $urandom_range(1, top);
      endcase
   endfunction

   // Position zero, or one from first_bad up to the top of the 7-bit range.
   function automatic int pick_bad_position(int first_bad);
      if (first_bad > 127 || $urandom_range(0, 2) == 0)
         return 0;
      return $urandom_range(first_bad, 127);
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus: a directed opening, then random segments of different shapes.
   // ------------------------------------------------------------------------
   initial begin
      int seg;
      int seg_mode;
      int seg_len;
      int k;
      int roll;
      bit drain;

      word_pool[0] = 32'sh8000_0000;
      word_pool[1] = 32'sh7FFF_FFFF;
      word_pool[2] = 32'sh0000_0000;
      word_pool[3] = -32'sd1;
      for (k = 4; k < 16; k++)
         word_pool[k] = $urandom;

      // Directed part. Failing positions are tried on the empty list first,
      // then a short list is built from the extreme words and worked over.
      queue_request(REQ_SEARCH, 127, 0, 1'b0);               // search without a match
      queue_request(REQ_REMOVE, 1, 0, 1'b0);                 // bad remove, list empty
      queue_request(REQ_MODIFY, 1, 7, 1'b0);                 // bad modify, list empty
      queue_request(REQ_INSERT, 0, 9, 1'b0);                 // position zero
      queue_request(REQ_INSERT, 2, 9, 1'b0);                 // above length plus one
      queue_request(REQ_INSERT, 1, 32'sh8000_0000, 1'b0);
      queue_request(REQ_INSERT, 2, 32'sh7FFF_FFFF, 1'b0);    // append
      queue_request(REQ_INSERT, 1, 0, 1'b0);                 // push to the front
      queue_request(REQ_INSERT, 127, -1, 1'b0);              // far out of range
      queue_request(REQ_SEARCH, 0, 32'sh7FFF_FFFF, 1'b0);
      queue_request(REQ_SEARCH, 64, 32'sh8000_0000, 1'b0);
      queue_request(REQ_MODIFY, 2, -1, 1'b0);
      queue_request(REQ_MODIFY, 4, 3, 1'b0);                 // one past the end
      queue_request(REQ_MODIFY, 3, 5, 1'b0);                 // last entry
      queue_request(REQ_SEARCH, 0, -1, 1'b0);
      queue_request(REQ_INSERT, 4, -1, 1'b0);                // duplicate at the end
      queue_request(REQ_SEARCH, 0, -1, 1'b0);                // first match must win
      queue_request(REQ_REMOVE, 0, 0, 1'b0);
      queue_request(REQ_REMOVE, 5, 0, 1'b0);
      queue_request(REQ_REMOVE, 2, 0, 1'b0);                 // from the middle
      queue_request(REQ_SEARCH, 0, -1, 1'b0);
      queue_request(REQ_REMOVE, 3, 0, 1'b0);                 // the last entry
      queue_request(REQ_REMOVE, 1, 0, 1'b0);                 // the first entry
      queue_request(REQ_SEARCH, 0, 5, 1'b0);
      queue_request(REQ_SEARCH, 0, 12345, 1'b0);

      // Random part. The first segment fills the list and keeps pushing past capacity and
      // the second empties it again; after that the shapes are drawn at random.
      for (seg = 0; pending_requests.size() < ITEM_TOTAL; seg++) begin
         seg_mode = (seg == 0) ? SEG_GROW : (seg == 1) ? SEG_SHRINK : $urandom_range(0, 3);
         seg_len = (seg < 2) ? 100 : $urandom_range(15, 60);
         for (k = 0; k < seg_len && pending_requests.size() < ITEM_TOTAL; k++) begin
            drain = (k == 0) && (seg == 0 || $urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
               // Noise: anything the ports can carry.
               queue_request(req_kind_type'($urandom_range(0, 3)), $urandom_range(0, 127),
                             $urandom, drain);
            end else begin
               case (seg_mode)
                  SEG_GROW: begin
                     if (roll < 80)
                        queue_request(REQ_INSERT, pick_valid_position(plan_length + 1),
                                      pick_word(60), drain);
                     else if (roll < 90)
                        queue_request(REQ_SEARCH, $urandom_range(0, 127), pick_word(75), drain);
                     else
                        queue_request(REQ_MODIFY, pick_valid_position(plan_length),
                                      pick_word(50), drain);
                  end
                  SEG_SHRINK: begin
                     if (roll < 80)
                        queue_request(REQ_REMOVE, pick_valid_position(plan_length),
                                      $urandom, drain);
                     else if (roll < 90)
                        queue_request(REQ_SEARCH, $urandom_range(0, 127), pick_word(75), drain);
                     else
                        queue_request(REQ_MODIFY, pick_valid_position(plan_length),
                                      pick_word(50), drain);
                  end
                  SEG_MIXED: begin
                     if (roll < 30)
                        queue_request(REQ_INSERT, pick_valid_position(plan_length + 1),
                                      pick_word(60), drain);
                     else if (roll < 52)
                        queue_request(REQ_REMOVE, pick_valid_position(plan_length),
                                      $urandom, drain);
                     else if (roll < 72)
                        queue_request(REQ_MODIFY, pick_valid_position(plan_length),
                                      pick_word(50), drain);
                     else
                        queue_request(REQ_SEARCH, $urandom_range(0, 127), pick_word(75), drain);
                  end
                  default: begin
                     // Broken requests: position zero, or positions just past, or far past, the end.
                     if (roll < 35)
                        queue_request(REQ_INSERT, pick_bad_position(plan_length + 2),
                                      pick_word(60), drain);
                     else if (roll < 60)
                        queue_request(REQ_REMOVE, pick_bad_position(plan_length + 1),
                                      $urandom, drain);
                     else if (roll < 80)
                        queue_request(REQ_MODIFY, pick_bad_position(plan_length + 1),
                                      pick_word(50), drain);
                     else
                        queue_request(REQ_SEARCH, $urandom_range(0, 127), pick_word(20), drain);
                  end
               endcase
            end
         end
      end
      planned_items = pending_requests.size();
   end

   // ------------------------------------------------------------------------
   // Reset: held from the start and released at a falling edge.
   // ------------------------------------------------------------------------
   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // Driver. It moves to a new word only when the current one was accepted
   // at the last rising edge or no word is on offer. After each word it counts
   // down the burst; at its end it draws a new burst length and a gap, which is
   // sometimes zero so that long unbroken stretches occur too.
   // ------------------------------------------------------------------------
   int burst_left = 0;
   int gap_left = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left != 0) begin
            req_valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_requests.size() != 0 &&
                      !(pending_requests[0].drain_first && expected_rsps.size() != 0)) begin
            next_request = pending_requests.pop_front();
            req_valid <= 1'b1;
            req_type <= next_request.kind;
            req_position <= next_request.position;
            req_value <= next_request.value;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            // Either out of words or waiting for the block to drain.
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver. Once, after enough requests have gone in, it holds off for a
   // long stretch while the driver keeps offering, so the block backs up and
   // stalls its input. Otherwise it switches between stall patterns.
   // ------------------------------------------------------------------------
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   int  stall_mode = STALL_NONE;
   int  mode_left = 0;
   int  stall_period = 3;
   int  stall_phase = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && accepted_reqs >= HOLD_AFTER) begin
         rsp_stall <= 1'b1;
         hold_left <= LONG_HOLD - 1;
         hold_done <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_period <= $urandom_range(2, 7);
            mode_left <= $urandom_range(20, 120);
         end else begin
            mode_left <= mode_left - 1;
         end
         stall_phase <= (stall_phase + 1 >= stall_period) ? 0 : stall_phase + 1;
         case (stall_mode)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_COIN:     rsp_stall <= 1'($urandom_range(0, 1));
            STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
            default:        rsp_stall <= (stall_phase == 0);
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Monitor. The result word is checked before the new request is predicted,
   // so an unexpected word can never be matched against this cycle's request.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         idle_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("result word arrived with no request outstanding");
               mismatch_count++;
            end else begin
               expected_word = expected_rsps.pop_front();
               if (rsp_success !== expected_word.success) begin
                  $error("success: expected %0d, got %0d", expected_word.success, rsp_success);
                  mismatch_count++;
               end
               if (rsp_found_position !== expected_word.found_position) begin
                  $error("found_position: expected %0d, got %0d",
                         expected_word.found_position, rsp_found_position);
                  mismatch_count++;
               end
               if (rsp_list_length !== expected_word.list_length) begin
                  $error("list_length: expected %0d, got %0d",
                         expected_word.list_length, rsp_list_length);
                  mismatch_count++;
               end
            end
            checked_rsps++;
         end
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(apply_request(req_kind_type'(req_type), req_position,
                                                  req_value));
            accepted_reqs++;
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: ends the run when no word has moved on either side for far
   // longer than the long hold-off plus the slowest search.
   // ------------------------------------------------------------------------
   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $error("no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
   end

   // ------------------------------------------------------------------------
   // End of run: once every request is in and every result is back, wait a
   // settling stretch for a stray word to show up, then report.
   // ------------------------------------------------------------------------
   initial begin
      @(negedge clock);
      while (reset || accepted_reqs != planned_items || expected_rsps.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (expected_rsps.size() != 0) begin
         $error("%0d result words never arrived", expected_rsps.size());
         mismatch_count++;
      end
      $display("Ran %0d requests, %0d results checked; peak length %0d of %0d.",
               accepted_reqs, checked_rsps, peak_length, CAPACITY);
      $display("Searches hit %0d, missed %0d; refused: %0d on a full list, %0d by position.",
               search_hits, search_misses, full_rejects, position_rejects);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

### positional_list_table_top.f
src/plt_pkg.sv
src/plt_cell.sv
src/positional_list_table_top.sv
tb/testbench.sv
